// ===== hw/rtl/ssm_pkg.sv =====
package ssm_pkg;

    localparam int SSM_MAX_SAMPLES = 32;
    localparam int SSM_SAMPLE_W    = 32;
    localparam int SSM_RESULT_W    = SSM_SAMPLE_W + 1;
    localparam int SSM_COUNT_W     = 6;

    typedef logic signed [SSM_SAMPLE_W-1:0] t_sample;
    typedef logic [SSM_COUNT_W-1:0]         t_count;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_MEDIAN = 1'b1
    } t_kind;

endpackage

// ===== hw/rtl/ssm_cell.sv =====
module ssm_cell
    import ssm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_ins,
    input  logic    i_shift,
    input  t_sample i_sample,
    input  t_sample i_left_val,
    input  logic    i_left_gt,
    input  t_sample i_right_val,
    input  logic    i_occ,
    output t_sample o_val,
    output logic    o_gt
);

    t_sample r_val;

    assign o_val = r_val;
    assign o_gt  = i_occ && (r_val > i_sample);

    // insert: take left neighbor if it moves right, else the new sample where it lands
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_right_val;
        end else if (i_ins) begin
            if (i_left_gt) begin
                r_val <= i_left_val;
            end else if (o_gt || !i_occ) begin
                r_val <= i_sample;
            end
        end
    end

endmodule

// ===== hw/rtl/ssm_chain.sv =====
module ssm_chain
    import ssm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_ins,
    input  logic    i_shift,
    input  t_sample i_sample,
    input  t_count  i_count,
    output t_sample o_head
);

    t_sample val [SSM_MAX_SAMPLES];
    logic    gt  [SSM_MAX_SAMPLES];

    assign o_head = val[0];

    for (genvar g = 0; g < SSM_MAX_SAMPLES; g++) begin : g_cell
        t_sample left_val;
        logic    left_gt;
        t_sample right_val;
        logic    occ;

        if (g == 0) begin : g_first
            assign left_val = '0;
            assign left_gt  = 1'b0;
        end else begin : g_mid
            assign left_val = val[g-1];
            assign left_gt  = gt[g-1];
        end

        if (g == SSM_MAX_SAMPLES - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_inner
            assign right_val = val[g+1];
        end

        assign occ = SSM_COUNT_W'(g) < i_count;

        ssm_cell u_cell (
            .i_clk       (i_clk),
            .i_ins       (i_ins),
            .i_shift     (i_shift),
            .i_sample    (i_sample),
            .i_left_val  (left_val),
            .i_left_gt   (left_gt),
            .i_right_val (right_val),
            .i_occ       (occ),
            .o_val       (val[g]),
            .o_gt        (gt[g])
        );
    end

endmodule

// ===== hw/rtl/sample_sort_median.sv =====
// Insertion: one transfer per cycle while not busy; a sample lands in its cell in the
// next cycle. Output run: batch end sets the state register, which loads the result
// register; then one result per cycle, kept count + 1 in all; busy is high until the
// median result. The chain drains through cell 0; the run is set by the kept count.
// Synchronous active-low reset clears count, overflow flag, state and the strobe.
// The receiver cannot stall: each result shows for exactly one cycle.
module sample_sort_median
    import ssm_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SSM_SAMPLE_W-1:0] i_sample_value,
    input  logic                           i_sample_present,
    input  logic                           i_batch_end,
    output logic                           o_result_valid,
    output logic                           o_result_kind,
    output logic signed [SSM_RESULT_W-1:0] o_result_value,
    output logic [SSM_COUNT_W-1:0]         o_sample_rank,
    output logic                           o_median_valid,
    output logic [SSM_COUNT_W-1:0]         o_sample_count,
    output logic                           o_overflow,
    output logic                           o_last_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAIN,
        S_MEDIAN
    } t_state;

    t_state  r_state;
    t_count  r_count;
    logic    r_dropped;
    t_count  r_idx;
    t_sample r_lo;
    t_sample r_hi;

    logic                    r_valid;
    t_kind                   r_kind;
    logic [SSM_RESULT_W-1:0] r_value;
    t_count                  r_rank;
    logic                    r_med_valid;
    t_count                  r_out_count;
    logic                    r_out_ovf;
    logic                    r_last;

    logic    accept;
    logic    full;
    logic    ins;
    t_sample head;
    t_count  half;
    t_count  n_count;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign full    = (r_count == SSM_COUNT_W'(SSM_MAX_SAMPLES));
    assign ins     = accept && i_sample_present && !full;
    assign half    = r_count >> 1;
    assign n_count = r_count + SSM_COUNT_W'(ins);

    ssm_chain u_chain (
        .i_clk    (i_clk),
        .i_ins    (ins),
        .i_shift  (r_state == S_DRAIN),
        .i_sample (i_sample_value),
        .i_count  (r_count),
        .o_head   (head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_idx     <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_count <= n_count;
                        if (i_sample_present && full) begin
                            r_dropped <= 1'b1;
                        end
                        if (i_batch_end) begin
                            r_idx   <= '0;
                            r_state <= (n_count != '0) ? S_DRAIN : S_MEDIAN;
                        end
                    end
                end
                S_DRAIN: begin
                    r_valid     <= 1'b1;
                    r_kind      <= KIND_SAMPLE;
                    r_value     <= {head, 1'b0};
                    r_rank      <= r_idx;
                    r_med_valid <= 1'b0;
                    r_out_count <= r_count;
                    r_out_ovf   <= r_dropped;
                    r_last      <= 1'b0;
                    if (r_idx == half - SSM_COUNT_W'(1)) begin
                        r_lo <= head;
                    end
                    if (r_idx == half) begin
                        r_hi <= head;
                    end
                    if (r_idx == r_count - SSM_COUNT_W'(1)) begin
                        r_state <= S_MEDIAN;
                    end else begin
                        r_idx <= r_idx + SSM_COUNT_W'(1);
                    end
                end
                S_MEDIAN: begin
                    r_valid     <= 1'b1;
                    r_kind      <= KIND_MEDIAN;
                    r_rank      <= '0;
                    r_out_count <= r_count;
                    r_out_ovf   <= r_dropped;
                    r_last      <= 1'b1;
                    if (r_count == '0) begin
                        r_value     <= '0;
                        r_med_valid <= 1'b0;
                    end else if (r_count[0]) begin
                        r_value     <= {r_hi, 1'b0};
                        r_med_valid <= 1'b1;
                    end else begin
                        r_value     <= {r_lo[SSM_SAMPLE_W-1], r_lo}
                                     + {r_hi[SSM_SAMPLE_W-1], r_hi};
                        r_med_valid <= 1'b1;
                    end
                    r_count   <= '0;
                    r_dropped <= 1'b0;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid = r_valid;
    assign o_result_kind  = r_kind;
    assign o_result_value = r_value;
    assign o_sample_rank  = r_rank;
    assign o_median_valid = r_med_valid;
    assign o_sample_count = r_out_count;
    assign o_overflow     = r_out_ovf;
    assign o_last_result  = r_last;

endmodule

// ===== hw/rtl/ssm_checker.sv =====
module ssm_checker
    import ssm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_batch_end,
    input logic o_result_valid,
    input logic o_result_kind,
    input logic o_median_valid,
    input logic o_last_result
);

    a_last_is_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_result) |-> (o_result_kind == KIND_MEDIAN))
        else $error("last result is not a median");

    a_sample_no_median_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result_kind == KIND_SAMPLE)) |-> !o_median_valid)
        else $error("sample result flags median valid");

    a_end_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_batch_end) |=> busy)
        else $error("batch end transfer did not start a run");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_result) |=> !o_result_valid)
        else $error("result follows the median directly");

endmodule

bind sample_sort_median ssm_checker u_ssm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_batch_end    (i_batch_end),
    .o_result_valid (o_result_valid),
    .o_result_kind  (o_result_kind),
    .o_median_valid (o_median_valid),
    .o_last_result  (o_last_result)
);

// ===== dv/median_run_checker.sv =====
module median_run_checker
    import ssm_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic signed [SSM_SAMPLE_W-1:0] i_sample_value,
    input  logic                           i_sample_present,
    input  logic                           i_batch_end,
    input  logic                           o_result_valid,
    input  logic                           o_result_kind,
    input  logic signed [SSM_RESULT_W-1:0] o_result_value,
    input  logic [SSM_COUNT_W-1:0]         o_sample_rank,
    input  logic                           o_median_valid,
    input  logic [SSM_COUNT_W-1:0]         o_sample_count,
    input  logic                           o_overflow,
    input  logic                           o_last_result,
    output int                             o_mismatch_count,
    output int                             o_runs_pending,
    output int                             o_batch_count,
    output int                             o_dropped_batches,
    output int                             o_results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_kind                          kind;
        logic signed [SSM_RESULT_W-1:0] value;
        t_count                         rank;
        logic                           median_ok;
        t_count                         count;
        logic                           dropped;
        logic                           last;
    } t_sorted_out;

    t_sample     ordered [SSM_MAX_SAMPLES];
    int          kept_n;
    logic        dropped_seen;
    t_sorted_out sorted_due[$];

    initial begin
        o_mismatch_count  = 0;
        o_batch_count     = 0;
        o_dropped_batches = 0;
        o_results_checked = 0;
        kept_n            = 0;
        dropped_seen      = 1'b0;
    end

    assign o_runs_pending = sorted_due.size();

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        o_mismatch_count++;
        if (o_mismatch_count <= 30)
            $display("%0t mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    task automatic place_and_release();
        int                             slot;
        int                             idx;
        logic signed [SSM_RESULT_W-1:0] lo;
        logic signed [SSM_RESULT_W-1:0] hi;
        t_sorted_out                    item;
        if (i_sample_present) begin
            if (kept_n >= SSM_MAX_SAMPLES) begin
                dropped_seen = 1'b1;
            end else begin
                slot = kept_n;
                while (slot > 0 && ordered[slot-1] > i_sample_value) begin
                    ordered[slot] = ordered[slot-1];
                    slot--;
                end
                ordered[slot] = i_sample_value;
                kept_n++;
            end
        end
        if (!i_batch_end)
            return;
        for (idx = 0; idx < kept_n; idx++) begin
            item.kind      = KIND_SAMPLE;
            item.value     = {ordered[idx], 1'b0};
            item.rank      = t_count'(idx);
            item.median_ok = 1'b0;
            item.count     = t_count'(kept_n);
            item.dropped   = dropped_seen;
            item.last      = 1'b0;
            sorted_due.push_back(item);
        end
        item.kind      = KIND_MEDIAN;
        item.value     = '0;
        item.rank      = '0;
        item.median_ok = (kept_n > 0);
        item.count     = t_count'(kept_n);
        item.dropped   = dropped_seen;
        item.last      = 1'b1;
        if (kept_n > 0) begin
            if (kept_n % 2 == 1) begin
                item.value = {ordered[kept_n/2], 1'b0};
            end else begin
                lo = ordered[kept_n/2 - 1];
                hi = ordered[kept_n/2];
                item.value = lo + hi;
            end
        end
        sorted_due.push_back(item);
        o_batch_count++;
        if (dropped_seen)
            o_dropped_batches++;
        kept_n       = 0;
        dropped_seen = 1'b0;
    endtask

    task automatic check_result();
        t_sorted_out want;
        if (sorted_due.size() == 0) begin
            flag_mismatch("result with nothing pending", 64'(o_result_value), 64'd0);
            return;
        end
        want = sorted_due.pop_front();
        o_results_checked++;
        if (o_result_kind !== want.kind)
            flag_mismatch("kind", 64'(o_result_kind), 64'(want.kind));
        if (o_result_value !== want.value)
            flag_mismatch("value", 64'(o_result_value), 64'(want.value));
        if (o_sample_rank !== want.rank)
            flag_mismatch("rank", 64'(o_sample_rank), 64'(want.rank));
        if (o_median_valid !== want.median_ok)
            flag_mismatch("median_valid", 64'(o_median_valid), 64'(want.median_ok));
        if (o_sample_count !== want.count)
            flag_mismatch("count", 64'(o_sample_count), 64'(want.count));
        if (o_overflow !== want.dropped)
            flag_mismatch("overflow", 64'(o_overflow), 64'(want.dropped));
        if (o_last_result !== want.last)
            flag_mismatch("last_result", 64'(o_last_result), 64'(want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kept_n       = 0;
            dropped_seen = 1'b0;
            sorted_due.delete();
        end else begin
            if (o_result_valid === 1'b1)
                check_result();
            else if (o_result_valid !== 1'b0)
                flag_mismatch("result strobe unknown", 64'd0, 64'd0);
            if (start && busy === 1'b0)
                place_and_release();
        end
    end

endmodule

// ===== dv/tb.sv =====
module tb;
    import ssm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 300;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic signed [SSM_SAMPLE_W-1:0] i_sample_value = '0;
    logic                           i_sample_present = 1'b0;
    logic                           i_batch_end = 1'b0;
    logic                           o_result_valid;
    logic                           o_result_kind;
    logic signed [SSM_RESULT_W-1:0] o_result_value;
    logic [SSM_COUNT_W-1:0]         o_sample_rank;
    logic                           o_median_valid;
    logic [SSM_COUNT_W-1:0]         o_sample_count;
    logic                           o_overflow;
    logic                           o_last_result;

    int      mismatches;
    int      runs_pending;
    int      batches_done;
    int      dropped_batches;
    int      results_checked;
    int      cycle_count = 0;
    int      transfers = 0;
    int      counted_items = 0;
    int      burst_left = 0;
    t_sample prev_sample = '0;

    sample_sort_median dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_sample_value   (i_sample_value),
        .i_sample_present (i_sample_present),
        .i_batch_end      (i_batch_end),
        .o_result_valid   (o_result_valid),
        .o_result_kind    (o_result_kind),
        .o_result_value   (o_result_value),
        .o_sample_rank    (o_sample_rank),
        .o_median_valid   (o_median_valid),
        .o_sample_count   (o_sample_count),
        .o_overflow       (o_overflow),
        .o_last_result    (o_last_result)
    );

    median_run_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_sample_value    (i_sample_value),
        .i_sample_present  (i_sample_present),
        .i_batch_end       (i_batch_end),
        .o_result_valid    (o_result_valid),
        .o_result_kind     (o_result_kind),
        .o_result_value    (o_result_value),
        .o_sample_rank     (o_sample_rank),
        .o_median_valid    (o_median_valid),
        .o_sample_count    (o_sample_count),
        .o_overflow        (o_overflow),
        .o_last_result     (o_last_result),
        .o_mismatch_count  (mismatches),
        .o_runs_pending    (runs_pending),
        .o_batch_count     (batches_done),
        .o_dropped_batches (dropped_batches),
        .o_results_checked (results_checked)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_sample pick_sample();
        t_sample v;
        case ($urandom_range(0, 9))
            0: v = 32'sh7FFF_FFFF;
            1: v = 32'sh8000_0000;
            2: v = t_sample'($urandom_range(0, 64)) - 32'sd32;
            3: v = prev_sample;
            4: v = t_sample'($urandom_range(0, 32'h00FF_FFFF));
            default: v = t_sample'($urandom);
        endcase
        prev_sample = v;
        return v;
    endfunction

    // hold start through a burst, drop it for a random gap between bursts
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send(input t_sample v, input logic present, input logic last_flag,
                        input bit counted);
        start            <= 1'b1;
        i_sample_value   <= v;
        i_sample_present <= present;
        i_batch_end      <= last_flag;
        do @(posedge i_clk); while (busy !== 1'b0);
        transfers++;
        if (counted)
            counted_items++;
        pace();
    endtask

    // let the checker see the last transfer, then wait out every pending result
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (runs_pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int  batch_len;
        int  k;
        bit  end_on_sample;
        int  batch_no;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(t_sample'($urandom), 1'b0, 1'b1, 1'b1);
        send(t_sample'($urandom), 1'b0, 1'b0, 1'b0);
        send(32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b1);
        send(32'sh8000_0000, 1'b1, 1'b0, 1'b1);
        send(32'sh0000_0000, 1'b1, 1'b0, 1'b1);
        send(32'shFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        send(32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b1);
        send(32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b1);
        send(32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b1);
        send(32'sh0000_0000, 1'b0, 1'b1, 1'b1);
        send(32'sh8000_0000, 1'b1, 1'b0, 1'b1);
        send(32'sh8000_0000, 1'b1, 1'b1, 1'b1);
        send(32'sh0001_0000, 1'b1, 1'b1, 1'b1);
        send(32'sh5555_AAAA, 1'b1, 1'b0, 1'b1);
        send(32'shAAAA_5555, 1'b1, 1'b0, 1'b1);
        send(32'shFFFF_0000, 1'b0, 1'b0, 1'b0);
        send(32'sh0000_3039, 1'b1, 1'b1, 1'b1);
        send(32'sh8000_0000, 1'b1, 1'b0, 1'b1);
        send(32'sh7FFF_FFFF, 1'b1, 1'b1, 1'b1);
        drain();

        counted_items = 0;
        batch_no      = 0;
        while (counted_items < RANDOM_ITEMS) begin
            if (batch_no == 0)
                batch_len = 33;
            else if ($urandom_range(0, 14) == 0)
                batch_len = $urandom_range(29, 36);
            else
                batch_len = $urandom_range(0, 9);
            end_on_sample = (batch_len > 0) && $urandom_range(0, 1);
            for (k = 0; k < batch_len; k++) begin
                if ($urandom_range(0, 7) == 0)
                    send(t_sample'($urandom), 1'b0, 1'b0, 1'b0);
                send(pick_sample(), 1'b1, end_on_sample && k == batch_len - 1, 1'b1);
            end
            if (!end_on_sample)
                send(t_sample'($urandom), 1'b0, 1'b1, 1'b1);
            batch_no++;
            if (batch_no == 20)
                drain();
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("Ran %0d transfers in %0d batches, %0d with dropped samples.",
                 transfers, batches_done, dropped_batches);
        $display("Compared %0d sorted and median results field by field.", results_checked);
        if (mismatches == 0 && runs_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
